FILE: rtl/core/cmst_pkg.sv
// Shared types, codes and sizes for the counting multiset table.
// No dependencies; every other file in rtl/core refers to it by scoped name.
`timescale 1ns / 1ps
`default_nettype none

package cmst_pkg;

	localparam int DEPTH      = 16;
	localparam int KEY_BITS   = 32;
	localparam int COUNT_BITS = 16;
	localparam int OP_BITS    = 2;
	localparam int OCC_BITS   = 16;
	localparam int ST_BITS    = 2;

	typedef logic [KEY_BITS-1:0]   key_t;
	typedef logic [COUNT_BITS-1:0] count_t;

	localparam count_t COUNT_MAX = '1;

	typedef enum logic [OP_BITS-1:0] {
		OP_QUERY  = 2'd0,
		OP_ADD    = 2'd1,
		OP_REMOVE = 2'd2
	} op_t;

	typedef enum logic [ST_BITS-1:0] {
		ST_OK   = 2'd0,
		ST_FULL = 2'd1,
		ST_SAT  = 2'd2
	} status_t;

	// Ripple passed from cell to cell during the compare cycle.
	typedef struct packed {
		logic   free;   // some lower-numbered entry is free
		logic   hit;    // some lower-numbered entry matched
		count_t count;  // count of the matching entry, zero if none yet
	} chain_t;

	// Write-back command broadcast to every cell.
	typedef struct packed {
		logic   fire;      // write-back cycle
		logic   hit_wr;    // matching entry takes the new count
		logic   hit_clr;   // matching entry is freed
		logic   claim_wr;  // claiming entry is filled with key and count one
		count_t count;
		key_t   key;
	} upd_t;

	// Per-cell flags latched at the end of the compare cycle.
	typedef struct packed {
		logic match;
		logic claim;
	} cell_st_t;

endpackage

`default_nettype wire

FILE: rtl/core/cmst_if.sv
// Valid/ready channel interfaces: request (operation, key) and response.
// Depends on cmst_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface cmst_req_if;
	logic                          valid;
	logic                          ready;
	logic [cmst_pkg::OP_BITS-1:0]  operation;
	logic [cmst_pkg::KEY_BITS-1:0] key;

	modport source (output valid, output operation, output key, input ready);
	modport sink   (input valid, input operation, input key, output ready);
endinterface

interface cmst_rsp_if;
	logic                          valid;
	logic                          ready;
	logic                          found;
	logic [cmst_pkg::OCC_BITS-1:0] occurrences;
	logic [cmst_pkg::ST_BITS-1:0]  status;

	modport source (output valid, output found, output occurrences, output status,
		input ready);
	modport sink   (input valid, input found, input occurrences, input status,
		output ready);
endinterface

`default_nettype wire

FILE: rtl/core/cmst_cell.sv
// One table entry: valid bit, key and count, with its link in the compare chain.
// Depends on cmst_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cmst_cell (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              step,
	input  wire cmst_pkg::key_t    key_s1,
	input  wire cmst_pkg::chain_t  chain_in,
	input  wire cmst_pkg::upd_t    upd,
	output cmst_pkg::chain_t       chain_out,
	output cmst_pkg::cell_st_t     st
);

	logic              valid_q;
	cmst_pkg::key_t    key_q;
	cmst_pkg::count_t  count_q;
	logic              match;
	logic              claim;
	logic              match_s2;
	logic              claim_s2;

	assign match = valid_q && (key_q == key_s1);
	// lowest free entry only
	assign claim = !valid_q && !chain_in.free;

	always_comb begin
		chain_out.free  = chain_in.free | ~valid_q;
		chain_out.hit   = chain_in.hit | match;
		chain_out.count = chain_in.count | (match ? count_q : '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_s2 <= 1'b0;
			claim_s2 <= 1'b0;
		end else if (step) begin
			match_s2 <= match;
			claim_s2 <= claim;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (upd.fire) begin
			if (match_s2 && upd.hit_clr) begin
				valid_q <= 1'b0;
			end else if (claim_s2 && upd.claim_wr) begin
				valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (upd.fire) begin
			if (match_s2 && upd.hit_wr) begin
				count_q <= upd.count;
			end else if (claim_s2 && upd.claim_wr) begin
				key_q   <= upd.key;
				count_q <= cmst_pkg::count_t'(1);
			end
		end
	end

	assign st.match = match_s2;
	assign st.claim = claim_s2;

endmodule

`default_nettype wire

FILE: rtl/core/counting_multiset_table_unit.sv
// Top level of the counting multiset table: request register, row of cmst_cell
// entries, result logic and response register. Depends on cmst_pkg and cmst_if.
//
//   channel | interface     | payload                          | per transfer
//   --------+---------------+----------------------------------+------------------
//   req     | cmst_req_if   | operation[1:0], key[31:0]        | one operation
//   rsp     | cmst_rsp_if   | found, occurrences[15:0],        | one result
//           |               | status[1:0]                      |
//
// Each operation passes through a compare cycle in which every cell checks
// its key and the free/hit chain ripples down the row, then a write-back cycle
// that updates at most one cell and loads the response register.
// A new request is not taken while the previous one is in its compare cycle,
// nor while its write-back is held by a waiting result.
// The next request is taken during the write-back cycle, so it compares
// against the updated table.
// arst_n clears all valid bits at once: the table is empty straight after
// reset, with no clearing pass.
// A result waiting in the response register holds the write-back stage; a
// request can still be accepted until then.
`timescale 1ns / 1ps
`default_nettype none

module counting_multiset_table_unit (
	input  wire logic   clk,
	input  wire logic   arst_n,
	cmst_req_if.sink    req,
	cmst_rsp_if.source  rsp
);

	localparam int DEPTH = cmst_pkg::DEPTH;

	// request stage (compare cycle)
	logic                           vld_s1;
	logic [cmst_pkg::OP_BITS-1:0]   op_s1;
	cmst_pkg::key_t                 key_s1;

	// write-back stage
	logic                           vld_s2;
	logic [cmst_pkg::OP_BITS-1:0]   op_s2;
	cmst_pkg::key_t                 key_s2;
	logic                           found_s2;
	logic                           full_s2;
	cmst_pkg::count_t               cnt_s2;

	// response register
	logic                           rsp_valid_q;
	logic                           found_q;
	logic [cmst_pkg::OCC_BITS-1:0]  occ_q;
	cmst_pkg::status_t              status_q;

	cmst_pkg::chain_t               chain [DEPTH+1];
	cmst_pkg::cell_st_t             cell_st [DEPTH];
	logic [DEPTH-1:0]               match_vec;
	logic [DEPTH-1:0]               claim_vec;
	cmst_pkg::upd_t                 upd;

	logic                           s2_fire;
	logic                           req_take;
	cmst_pkg::count_t               new_cnt;
	cmst_pkg::status_t              new_st;
	logic                           hit_wr;
	logic                           hit_clr;
	logic                           claim_wr;

	// A transfer on rsp frees the response slot in the same cycle.
	assign s2_fire  = vld_s2 && (!rsp_valid_q || rsp.ready);
	assign req.ready = !vld_s1 && (!vld_s2 || s2_fire);
	assign req_take = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= req_take;
			if (vld_s1) begin
				vld_s2 <= 1'b1;
			end else if (s2_fire) begin
				vld_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_take) begin
			op_s1  <= req.operation;
			key_s1 <= req.key[cmst_pkg::KEY_BITS-1:0];
		end
		if (vld_s1) begin
			op_s2    <= op_s1;
			key_s2   <= key_s1;
			found_s2 <= chain[DEPTH].hit;
			full_s2  <= !chain[DEPTH].free;
			cnt_s2   <= chain[DEPTH].count;
		end
	end

	// ---- cell row ----
	assign chain[0] = '{free: 1'b0, hit: 1'b0, count: '0};

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		cmst_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.step      (vld_s1),
			.key_s1    (key_s1),
			.chain_in  (chain[i]),
			.upd       (upd),
			.chain_out (chain[i+1]),
			.st        (cell_st[i])
		);
		assign match_vec[i] = cell_st[i].match;
		assign claim_vec[i] = cell_st[i].claim;
	end

	// ---- result and write-back command ----
	always_comb begin
		new_cnt  = '0;
		new_st   = cmst_pkg::ST_OK;
		hit_wr   = 1'b0;
		hit_clr  = 1'b0;
		claim_wr = 1'b0;
		case (op_s2)
			cmst_pkg::OP_ADD: begin
				if (found_s2) begin
					hit_wr = 1'b1;
					if (cnt_s2 == cmst_pkg::COUNT_MAX) begin
						new_cnt = cmst_pkg::COUNT_MAX;
						new_st  = cmst_pkg::ST_SAT;
					end else begin
						new_cnt = cmst_pkg::count_t'(cnt_s2 + 1'b1);
					end
				end else if (full_s2) begin
					new_st = cmst_pkg::ST_FULL;
				end else begin
					claim_wr = 1'b1;
					new_cnt  = cmst_pkg::count_t'(1);
				end
			end
			cmst_pkg::OP_REMOVE: begin
				if (found_s2) begin
					if (cnt_s2 <= cmst_pkg::count_t'(1)) begin
						hit_clr = 1'b1;
					end else begin
						hit_wr  = 1'b1;
						new_cnt = cmst_pkg::count_t'(cnt_s2 - 1'b1);
					end
				end
			end
			default: begin
				// query, and the unused code behaves as one
				new_cnt = cnt_s2;
			end
		endcase
	end

	always_comb begin
		upd.fire     = s2_fire;
		upd.hit_wr   = hit_wr;
		upd.hit_clr  = hit_clr;
		upd.claim_wr = claim_wr;
		upd.count    = new_cnt;
		upd.key      = key_s2;
	end

	// ---- response register ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (s2_fire) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_fire) begin
			found_q  <= found_s2;
			occ_q    <= cmst_pkg::OCC_BITS'(new_cnt);
			status_q <= new_st;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.found       = found_q;
	assign rsp.occurrences = occ_q;
	assign rsp.status      = status_q;

	// ---- checks ----
	a_one_match: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 |-> $onehot0(match_vec))
		else $error("more than one entry holds the key");

	a_one_claim: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 |-> $onehot0(claim_vec))
		else $error("more than one entry claimed");

	a_s1_to_s2: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |=> vld_s2 && !vld_s1)
		else $error("compare stage did not pass to write-back");

	a_full_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && status_q == cmst_pkg::ST_FULL |-> !found_q && occ_q == '0)
		else $error("dropped add reported a count");

	a_sat_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		s2_fire && new_st == cmst_pkg::ST_SAT |-> found_s2 && hit_wr && !claim_wr)
		else $error("saturation without a hit");

endmodule

`default_nettype wire
